>>> hdl/gbc_pkg.sv
// Shared constants, types and table functions for the geofence breach check.
`timescale 1ns / 1ps
package gbc_pkg;

	localparam int CORDIC_STAGES_DEF = 24;
	localparam int ANGLE_FRAC_BITS   = 30;

	// CORDIC datapath widths: x/y hold up to gain*2^30, z up to pi/2 in Q30
	localparam int XW = 33;
	localparam int ZW = 33;
	// sqrt of a Q60 value: one stage per result bit
	localparam int SQRT_STAGES = ANGLE_FRAC_BITS + 1;

	localparam logic signed [XW-1:0] ONE_X = XW'(64'd1 << ANGLE_FRAC_BITS);

	localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
	localparam logic [31:0] PI_FX  = 32'(((PI_Q61 >> 30) + 64'd1) >> 1);

	localparam logic [31:0] DIV_HALF = 32'd3600000000;
	localparam logic [31:0] DIV_FULL = 32'd1800000000;
	// floor(PI_FX * 2^32 / D): estimate is never high and at most one low
	localparam logic [32:0] RECIP_HALF = 33'({PI_FX, 32'd0} / {32'd0, DIV_HALF});
	localparam logic [32:0] RECIP_FULL = 33'({PI_FX, 32'd0} / {32'd0, DIV_FULL});

	localparam logic [25:0] EARTH_R_DM = 26'd63710000;
	localparam logic [28:0] THR_RECIP  = 29'((64'd1 << 54) / 64'd63710000);

	typedef enum logic [1:0] {
		CFG_ENABLED = 2'd0,
		CFG_LAT     = 2'd1,
		CFG_LON     = 2'd2,
		CFG_RADIUS  = 2'd3
	} gbc_cfg_idx_t;

	typedef struct packed {
		logic vld;
		logic chk;
	} gbc_ctl_t;

	// restoring long division, only used while building constant tables
	function automatic longint unsigned udiv64(input longint unsigned n,
		input longint unsigned d);
		longint unsigned quo;
		longint unsigned rem;
		int              b;
		quo = 0;
		rem = 0;
		for (b = 63; b >= 0; b--) begin
			rem = {rem[62:0], n[b]};
			if (rem >= d) begin
				rem    = rem - d;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// atan(2^-i) in Q30, from the alternating series in Q61
	function automatic logic [31:0] atan_fx(input int i);
		longint v;
		longint t;
		int     k;
		int     sgn;
		v   = 0;
		sgn = 1;
		if (i == 0) begin
			v = longint'(PI_Q61 >> 2);
		end else begin
			for (k = 1; k * i <= 61; k += 2) begin
				t = longint'(udiv64(64'd1 << (61 - k * i), 64'(k)));
				v = (sgn > 0) ? v + t : v - t;
				sgn = -sgn;
			end
		end
		return 32'((v + (64'sd1 << 30)) >>> 31);
	endfunction

	// squared inverse CORDIC gain in Q30
	function automatic logic [29:0] g2_fx(input int n);
		longint unsigned q;
		int              i;
		q = 64'd1 << 62;
		for (i = 0; i < n; i++) begin
			q = q - udiv64(q, (64'd1 << (2 * i)) + 64'd1);
		end
		return 30'((q + 64'd2147483648) >> 32);
	endfunction

endpackage

>>> hdl/gbc_rot.sv
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
`timescale 1ns / 1ps
module gbc_rot import gbc_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input  logic                 clk,
	input  logic                 adv,
	input  logic signed [ZW-1:0] z_in,
	input  logic                 tag_in,
	output logic signed [XW-1:0] cos_out,
	output logic signed [XW-1:0] sin_out,
	output logic                 tag_out
);

	logic signed [XW-1:0] x_s [STAGES];
	logic signed [XW-1:0] y_s [STAGES];
	logic signed [ZW-1:0] z_s [STAGES];
	logic                 t_s [STAGES];

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam logic signed [ZW-1:0] ATAN = $signed({1'b0, atan_fx(i)});
		logic signed [XW-1:0] xp;
		logic signed [XW-1:0] yp;
		logic signed [ZW-1:0] zp;
		logic                 tp;

		if (i == 0) begin : g_first
			assign xp = ONE_X;
			assign yp = '0;
			assign zp = z_in;
			assign tp = tag_in;
		end else begin : g_next
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign tp = t_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (zp >= 0) begin
					x_s[i] <= xp - (yp >>> i);
					y_s[i] <= yp + (xp >>> i);
					z_s[i] <= zp - ATAN;
				end else begin
					x_s[i] <= xp + (yp >>> i);
					y_s[i] <= yp - (xp >>> i);
					z_s[i] <= zp + ATAN;
				end
				t_s[i] <= tp;
			end
		end
	end

	assign cos_out = x_s[STAGES-1];
	assign sin_out = y_s[STAGES-1];
	assign tag_out = t_s[STAGES-1];

endmodule

>>> hdl/gbc_isqrt.sv
// Pipelined floor square root of a Q60 value, one result bit per stage.
`timescale 1ns / 1ps
module gbc_isqrt import gbc_pkg::*; (
	input  logic                       clk,
	input  logic                       adv,
	input  logic [2*SQRT_STAGES-2:0]   v_in,
	output logic [SQRT_STAGES-1:0]     root
);

	localparam int W = 2 * SQRT_STAGES;

	logic [W-1:0] v_s [SQRT_STAGES];
	logic [W-1:0] r_s [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
		logic [W-1:0] vp;
		logic [W-1:0] rp;
		logic [W-1:0] trial;

		if (k == 0) begin : g_first
			assign vp = W'(v_in);
			assign rp = '0;
		end else begin : g_next
			assign vp = v_s[k-1];
			assign rp = r_s[k-1];
		end

		assign trial = rp + BIT;

		always_ff @(posedge clk) begin
			if (adv) begin
				if (vp >= trial) begin
					v_s[k] <= vp - trial;
					r_s[k] <= (rp >> 1) + BIT;
				end else begin
					v_s[k] <= vp;
					r_s[k] <= rp >> 1;
				end
			end
		end
	end

	assign root = r_s[SQRT_STAGES-1][SQRT_STAGES-1:0];

endmodule

>>> hdl/geofence_breach_check_top.sv
// Geofence breach check: haversine distance test of a GPS fix against a circular fence.
// Throughput: one fix per cycle; the whole pipeline holds only while a result waits on rsp_stall.
// Depth is set by a rotation and a vectoring CORDIC pass around the 31-stage square root.
// Reset: fence registers return to their defaults and all pipeline valid bits clear.
`timescale 1ns / 1ps
module geofence_breach_check_top import gbc_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               fix_valid,
	input  logic signed [30:0] latitude,
	input  logic signed [31:0] longitude,
	input  logic [15:0]        accuracy_dm,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic               breach,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int N   = CORDIC_STAGES;
	localparam int LAT = 9 + N + SQRT_STAGES + N;
	localparam logic [29:0] G2 = g2_fx(N);
	localparam logic signed [33:0] FULL_TURN = 34'sd3600000000;
	localparam logic signed [33:0] HALF_TURN = 34'sd1800000000;
	localparam logic [31:0] QUARTER = 32'd900000000;
	localparam logic [31:0] HALF_DEG = 32'd1800000000;
	localparam logic [15:0] ACC_MAX = 16'd300;

	// configuration
	logic               fence_enabled_q;
	logic signed [30:0] fence_lat_q;
	logic signed [31:0] fence_lon_q;
	logic [19:0]        fence_radius_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fence_enabled_q <= 1'b0;
			fence_lat_q     <= 31'sd320609000;
			fence_lon_q     <= 32'sd1187780000;
			fence_radius_q  <= 20'd1000;
		end else if (cfg_valid) begin
			case (gbc_cfg_idx_t'(cfg_index))
				CFG_ENABLED: fence_enabled_q <= cfg_data[0];
				CFG_LAT:     fence_lat_q     <= cfg_data[30:0];
				CFG_LON:     fence_lon_q     <= cfg_data;
				CFG_RADIUS:  fence_radius_q  <= cfg_data[19:0];
				default:     fence_enabled_q <= fence_enabled_q;
			endcase
		end
	end

	// radius -> angle threshold, registered through tq_q, tqe_q/tq2_q and thr_q after a write
	logic [48:0] tprod;
	logic [24:0] tq_q;
	logic [24:0] tq2_q;
	logic [50:0] tqe_q;
	logic [24:0] thr_q;
	logic [49:0] rad_sh;

	assign tprod  = 49'(fence_radius_q) * 49'(THR_RECIP);
	assign rad_sh = {fence_radius_q, 30'd0};

	always_ff @(posedge clk) begin
		tq_q  <= tprod[48:24];
		tqe_q <= 51'(tq_q) * 51'(EARTH_R_DM);
		tq2_q <= tq_q;
		thr_q <= tq2_q + 25'((51'(rad_sh) - tqe_q) >= 51'(EARTH_R_DM));
	end

	// pipeline control
	logic     adv;
	gbc_ctl_t ctl_s [LAT];

	assign adv       = !(rsp_valid && rsp_stall);
	assign req_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				ctl_s[k] <= '0;
			end
		end else if (adv) begin
			ctl_s[0].vld <= req_valid;
			ctl_s[0].chk <= fence_enabled_q && fix_valid && (accuracy_dm <= ACC_MAX);
			for (int k = 1; k < LAT; k++) begin
				ctl_s[k] <= ctl_s[k-1];
			end
		end
	end

	// stage 1: differences, wrap and latitude fold
	function automatic logic signed [33:0] wrap_deg(input logic signed [33:0] d);
		logic signed [33:0] m;
		m = d;
		if (d >= FULL_TURN) m = d - FULL_TURN;
		else if (d <= -FULL_TURN) m = d + FULL_TURN;
		if (m >= HALF_TURN) m = m - FULL_TURN;
		else if (m < -HALF_TURN) m = m + FULL_TURN;
		return m;
	endfunction

	logic signed [33:0] dlat_w;
	logic signed [33:0] dlon_w;
	logic [30:0]        mag_in [4];
	logic               neg_in [4];
	logic signed [31:0] lat_e [2];
	logic [31:0]        lat_m [2];

	always_comb begin
		dlat_w    = wrap_deg(34'(latitude) - 34'(fence_lat_q));
		dlon_w    = wrap_deg(34'(longitude) - 34'(fence_lon_q));
		neg_in[0] = dlat_w < 0;
		mag_in[0] = 31'(neg_in[0] ? -dlat_w : dlat_w);
		neg_in[1] = dlon_w < 0;
		mag_in[1] = 31'(neg_in[1] ? -dlon_w : dlon_w);
		lat_e[0]  = 32'(fence_lat_q);
		lat_e[1]  = 32'(latitude);
		for (int j = 0; j < 2; j++) begin
			lat_m[j]    = lat_e[j] < 0 ? 32'(-lat_e[j]) : 32'(lat_e[j]);
			neg_in[2+j] = lat_m[j] > QUARTER;
			mag_in[2+j] = 31'(neg_in[2+j] ? HALF_DEG - lat_m[j] : lat_m[j]);
		end
	end

	// lanes: half dlat, half dlon, fence latitude, fix latitude
	logic signed [XW-1:0] rot_c [4];
	logic signed [XW-1:0] rot_s [4];
	logic                 rot_t [4];

	for (genvar l = 0; l < 4; l++) begin : g_lane
		localparam logic [32:0] RECIP = (l < 2) ? RECIP_HALF : RECIP_FULL;
		localparam logic [31:0] DIV   = (l < 2) ? DIV_HALF : DIV_FULL;

		logic [30:0]          mag_s1;
		logic                 neg_s1;
		logic [63:0]          prodr_s2;
		logic [62:0]          exact_s2;
		logic                 neg_s2;
		logic [30:0]          qa_s3;
		logic [62:0]          exact_s3;
		logic                 neg_s3;
		logic [30:0]          qa_s4;
		logic [62:0]          qd_s4;
		logic [62:0]          exact_s4;
		logic                 neg_s4;
		logic signed [ZW-1:0] ang_s5;
		logic                 neg_s5;
		logic [30:0]          q_fix;

		assign q_fix = qa_s4 + 31'((exact_s4 - qd_s4) >= 63'(DIV));

		always_ff @(posedge clk) begin
			if (adv) begin
				mag_s1   <= mag_in[l];
				neg_s1   <= neg_in[l];
				prodr_s2 <= 64'(mag_s1) * 64'(RECIP);
				exact_s2 <= 63'(mag_s1) * 63'(PI_FX);
				neg_s2   <= neg_s1;
				qa_s3    <= prodr_s2[62:32];
				exact_s3 <= exact_s2;
				neg_s3   <= neg_s2;
				qd_s4    <= 63'(qa_s3) * 63'(DIV);
				qa_s4    <= qa_s3;
				exact_s4 <= exact_s3;
				neg_s4   <= neg_s3;
				// half-angle lanes carry the sign in z, cosine lanes flip later
				if (l < 2 && neg_s4) ang_s5 <= -$signed({2'b00, q_fix});
				else                 ang_s5 <= $signed({2'b00, q_fix});
				neg_s5   <= (l >= 2) && neg_s4;
			end
		end

		gbc_rot #(.STAGES(N)) u_rot (
			.clk     (clk),
			.adv     (adv),
			.z_in    (ang_s5),
			.tag_in  (neg_s5),
			.cos_out (rot_c[l]),
			.sin_out (rot_s[l]),
			.tag_out (rot_t[l])
		);
	end

	// haversine term a
	logic signed [XW-1:0] c1_w;
	logic signed [XW-1:0] c2_w;
	logic signed [65:0]   sq1_w;
	logic signed [65:0]   sq2_w;
	logic signed [65:0]   pc_w;
	logic [61:0]          p1_s1m;
	logic [61:0]          p2_s1m;
	logic signed [63:0]   pc_s1m;
	logic [31:0]          t1_s2m;
	logic [31:0]          sq2_s2m;
	logic signed [33:0]   cc_s2m;
	logic [61:0]          t1p_w;
	logic [61:0]          sq2p_w;
	logic signed [63:0]   ccp_w;
	logic [31:0]          t1_s3m;
	logic signed [35:0]   t2_s3m;
	logic signed [65:0]   t2p_w;
	logic signed [36:0]   a_w;
	logic [30:0]          a_cl;
	logic [60:0]          sa_arg_s4m;
	logic [60:0]          ca_arg_s4m;

	assign c1_w  = rot_t[2] ? -rot_c[2] : rot_c[2];
	assign c2_w  = rot_t[3] ? -rot_c[3] : rot_c[3];
	assign sq1_w = 66'(rot_s[0]) * 66'(rot_s[0]);
	assign sq2_w = 66'(rot_s[1]) * 66'(rot_s[1]);
	assign pc_w  = 66'(c1_w) * 66'(c2_w);

	assign t1p_w  = 62'(p1_s1m[61:30]) * 62'(G2);
	assign sq2p_w = 62'(p2_s1m[61:30]) * 62'(G2);
	assign ccp_w  = 64'(pc_s1m >>> 30) * $signed({34'd0, G2});
	assign t2p_w  = 66'(cc_s2m) * $signed({34'd0, sq2_s2m});

	always_comb begin
		a_w = 37'(t2_s3m) + $signed({5'd0, t1_s3m});
		if (a_w < 0) a_cl = '0;
		else if (a_w > $signed(37'(ONE_X))) a_cl = 31'(ONE_X);
		else a_cl = 31'(a_w);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s1m     <= 62'(sq1_w);
			p2_s1m     <= 62'(sq2_w);
			pc_s1m     <= 64'(pc_w);
			t1_s2m     <= t1p_w[61:30];
			sq2_s2m    <= sq2p_w[61:30];
			cc_s2m     <= 34'(ccp_w >>> 30);
			t1_s3m     <= t1_s2m;
			t2_s3m     <= 36'(t2p_w >>> 30);
			sa_arg_s4m <= {a_cl, 30'd0};
			ca_arg_s4m <= {31'(ONE_X) - a_cl, 30'd0};
		end
	end

	// square roots of a and 1-a
	logic [SQRT_STAGES-1:0] sa_root;
	logic [SQRT_STAGES-1:0] ca_root;

	gbc_isqrt u_sqrt_sa (
		.clk  (clk),
		.adv  (adv),
		.v_in (sa_arg_s4m),
		.root (sa_root)
	);

	gbc_isqrt u_sqrt_ca (
		.clk  (clk),
		.adv  (adv),
		.v_in (ca_arg_s4m),
		.root (ca_root)
	);

	// vectoring CORDIC for atan2(sa, ca)
	logic signed [33:0]   vx_s [N];
	logic signed [33:0]   vy_s [N];
	logic signed [ZW-1:0] vz_s [N];
	logic                 vzero_s [N];

	for (genvar i = 0; i < N; i++) begin : g_vec
		localparam logic signed [ZW-1:0] ATAN = $signed({1'b0, atan_fx(i)});
		logic signed [33:0]   xp;
		logic signed [33:0]   yp;
		logic signed [ZW-1:0] zp;
		logic                 zf;

		if (i == 0) begin : g_first
			assign xp = $signed(34'(ca_root));
			assign yp = $signed(34'(sa_root));
			assign zp = '0;
			assign zf = (sa_root == '0);
		end else begin : g_next
			assign xp = vx_s[i-1];
			assign yp = vy_s[i-1];
			assign zp = vz_s[i-1];
			assign zf = vzero_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (yp >= 0) begin
					vx_s[i] <= xp + (yp >>> i);
					vy_s[i] <= yp - (xp >>> i);
					vz_s[i] <= zp + ATAN;
				end else begin
					vx_s[i] <= xp - (yp >>> i);
					vy_s[i] <= yp + (xp >>> i);
					vz_s[i] <= zp - ATAN;
				end
				vzero_s[i] <= zf;
			end
		end
	end

	// central angle 2*theta against the radius threshold
	logic signed [33:0] theta2;
	logic signed [33:0] thr_x;

	assign theta2 = vzero_s[N-1] ? 34'sd0 : {vz_s[N-1], 1'b0};
	assign thr_x  = $signed({9'd0, thr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv) begin
			rsp_valid <= ctl_s[LAT-1].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			breach <= ctl_s[LAT-1].chk && (theta2 > thr_x);
		end
	end

endmodule
